/* design/clt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants of the command line tokenizer: scan modes,
// result kinds, the result item and the per-byte result list.
// ----------------------------------------------------------------------------
package clt_pkg;

    // default token limit per line
    localparam int MAX_TOKENS_DEF = 1024;

    // fixed field widths
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;

    // most results one byte can cause
    localparam int MAX_RES = 4;
    localparam int RES_W   = $clog2(MAX_RES + 1);
    localparam int RPTR_W  = $clog2(MAX_RES);

    // character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;

    // scanner modes
    typedef enum logic [2:0] {
        MODE_BETWEEN       = 3'd0,
        MODE_TOKEN         = 3'd1,
        MODE_QUOTED        = 3'd2,
        MODE_LINE_COMMENT  = 3'd3,
        MODE_BLOCK_COMMENT = 3'd4,
        MODE_TOKEN_PROTO   = 3'd5,
        MODE_STOPPED       = 3'd6
    } mode_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    // one result item
    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        logic              ovf;
        logic              last;
    } item_t;

    // results of one byte, handed from the scanner to the result buffer
    typedef struct packed {
        logic                      load;
        logic [RES_W-1:0]          count;
        item_t [MAX_RES-1:0]       items;
    } res_list_t;

endpackage

/* design/command_line_tokenizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Splits a streamed command line into tokens, skipping comments.
// ----------------------------------------------------------------------------
// Usage:
// - input channel s_*: one line byte per request, s_end_of_line on the last
//   byte of the line; accepted when s_valid and s_ready are high
// - result channel m_*: token bytes, token ends and one line-done request per
//   line with the token count and the overflow flag; m_last marks the final
//   result caused by an input byte
// - cfg_*: write of ignore_quotes, always ready; write only while idle
// - a byte is held in the input register, then its results are loaded into
//   the result buffer, which presents them on m_*
// - throughput: one byte per cycle while each byte causes at most one
//   result and m_ready stays high; a byte with more results holds the input
//   register until the result buffer, one entry per handshake, has drained
// - a stalled receiver keeps the results in the buffer; the input register
//   still takes one more byte, then s_ready drops
// - reset clears the scan state, the buffers and ignore_quotes
// ----------------------------------------------------------------------------
module command_line_tokenizer #(
    parameter int MAX_TOKENS = clt_pkg::MAX_TOKENS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [clt_pkg::CHAR_W-1:0] s_char_in,
    input  logic                       s_end_of_line,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_item_kind,
    output logic [clt_pkg::CHAR_W-1:0] m_char_out,
    output logic [clt_pkg::IDX_W-1:0]  m_token_index,
    output logic                       m_overflow,
    output logic                       m_last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data
);

    logic               ignore_quotes_reg;
    logic               buf_free;
    clt_pkg::res_list_t res_list;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignore_quotes_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            ignore_quotes_reg <= cfg_data;
        end
    end

    // scanner
    clt_scanner #(
        .MAX_TOKENS(MAX_TOKENS)
    ) u_scanner (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ignore_quotes (ignore_quotes_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_in     (s_char_in),
        .s_end_of_line (s_end_of_line),
        .buf_free      (buf_free),
        .res_out       (res_list)
    );

    // result buffer
    clt_result_buf u_result_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_in        (res_list),
        .buf_free      (buf_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item_kind   (m_item_kind),
        .m_char_out    (m_char_out),
        .m_token_index (m_token_index),
        .m_overflow    (m_overflow),
        .m_last        (m_last)
    );

endmodule

/* design/clt_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_scanner
// Input register and scan state of the tokenizer; works out all results of
// one byte combinationally and hands them to the result buffer.
// ----------------------------------------------------------------------------
module clt_scanner #(
    parameter int MAX_TOKENS = clt_pkg::MAX_TOKENS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       ignore_quotes,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [clt_pkg::CHAR_W-1:0] s_char_in,
    input  logic                       s_end_of_line,
    input  logic                       buf_free,
    output clt_pkg::res_list_t         res_out
);

    localparam int CNT_W = $clog2(MAX_TOKENS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKENS);

    // input register
    logic                       in_valid_reg;
    logic [clt_pkg::CHAR_W-1:0] in_char_reg;
    logic                       in_eol_reg;

    // scan state
    clt_pkg::mode_t             mode_reg, mode_next;
    logic                       pslash_reg, pslash_next;
    logic [clt_pkg::CHAR_W-1:0] prev_reg, prev_next;
    logic [clt_pkg::CHAR_W-1:0] sprev_reg, sprev_next;
    logic [1:0]                 lpos_reg, lpos_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       star_reg, star_next;

    logic                       consume;
    clt_pkg::res_list_t         list;

    assign consume = in_valid_reg & buf_free;
    assign s_ready = ~in_valid_reg | consume;

    // counter value to token index field
    function automatic logic [clt_pkg::IDX_W-1:0] to_idx(input logic [CNT_W-1:0] v);
        logic [CNT_W+clt_pkg::IDX_W-1:0] wide;
        wide = {{clt_pkg::IDX_W{1'b0}}, v};
        return wide[clt_pkg::IDX_W-1:0];
    endfunction

    // index of the current token
    function automatic logic [clt_pkg::IDX_W-1:0] cur_idx(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] d;
        d = (v == '0) ? '0 : v - CNT_W'(1);
        return to_idx(d);
    endfunction

    // append one result, dropping anything past the list size
    function automatic clt_pkg::res_list_t put_item(
        input clt_pkg::res_list_t      l,
        input clt_pkg::kind_t          kind,
        input logic [clt_pkg::CHAR_W-1:0] ch,
        input logic [clt_pkg::IDX_W-1:0]  idx,
        input logic                    ovf
    );
        clt_pkg::res_list_t r;
        r = l;
        if (r.count < clt_pkg::RES_W'(clt_pkg::MAX_RES)) begin
            r.items[r.count[clt_pkg::RPTR_W-1:0]].kind = kind;
            r.items[r.count[clt_pkg::RPTR_W-1:0]].ch   = ch;
            r.items[r.count[clt_pkg::RPTR_W-1:0]].idx  = idx;
            r.items[r.count[clt_pkg::RPTR_W-1:0]].ovf  = ovf;
            r.items[r.count[clt_pkg::RPTR_W-1:0]].last = 1'b0;
            r.count = r.count + clt_pkg::RES_W'(1);
        end
        return r;
    endfunction

    // per-byte scan step
    always_comb begin
        logic [clt_pkg::CHAR_W-1:0] c;
        clt_pkg::mode_t             md;
        logic                       ps;
        logic [CNT_W-1:0]           cnt;
        logic                       ss;
        logic                       do_tok;
        logic                       ok;
        logic                       is_sep;
        logic                       is_quote;
        logic                       proto;
        clt_pkg::res_list_t         l;

        c        = in_char_reg;
        md       = mode_reg;
        ps       = pslash_reg;
        cnt      = cnt_reg;
        ss       = star_reg;
        do_tok   = 1'b0;
        ok       = 1'b1;
        l        = '0;
        is_sep   = (c <= clt_pkg::CH_SPACE);
        is_quote = ~ignore_quotes & (c == clt_pkg::CH_QUOTE);
        proto    = (lpos_reg == 2'd3) && (prev_reg == clt_pkg::CH_COLON) &&
                   (sprev_reg >= clt_pkg::CH_LOW_A) && (sprev_reg <= clt_pkg::CH_LOW_Z);

        // held slash decides between comment and plain byte
        if (ps) begin
            if (c == clt_pkg::CH_STAR ||
                (c == clt_pkg::CH_SLASH && md != clt_pkg::MODE_TOKEN_PROTO)) begin
                ps = 1'b0;
                if (md != clt_pkg::MODE_BETWEEN) begin
                    l = put_item(l, clt_pkg::KIND_END, '0, cur_idx(cnt), 1'b0);
                end
                md = (c == clt_pkg::CH_STAR) ? clt_pkg::MODE_BLOCK_COMMENT
                                             : clt_pkg::MODE_LINE_COMMENT;
                ss = 1'b0;
            end else begin
                ps = 1'b0;
                if (md == clt_pkg::MODE_BETWEEN) begin
                    if (cnt >= CNT_MAX) begin
                        md = clt_pkg::MODE_STOPPED;
                        ok = 1'b0;
                    end else begin
                        cnt = cnt + CNT_W'(1);
                    end
                end
                if (ok) begin
                    l      = put_item(l, clt_pkg::KIND_BYTE, clt_pkg::CH_SLASH,
                                      cur_idx(cnt), 1'b0);
                    md     = clt_pkg::MODE_TOKEN;
                    do_tok = 1'b1;
                end
            end
        end else begin
            unique case (md)
                clt_pkg::MODE_BETWEEN: begin
                    if (is_sep) begin
                        md = clt_pkg::MODE_BETWEEN;
                    end else if (is_quote) begin
                        if (cnt >= CNT_MAX) begin
                            md = clt_pkg::MODE_STOPPED;
                        end else begin
                            cnt = cnt + CNT_W'(1);
                            md  = clt_pkg::MODE_QUOTED;
                        end
                    end else if (c == clt_pkg::CH_SLASH) begin
                        ps = 1'b1;
                    end else if (cnt >= CNT_MAX) begin
                        md = clt_pkg::MODE_STOPPED;
                    end else begin
                        cnt = cnt + CNT_W'(1);
                        l   = put_item(l, clt_pkg::KIND_BYTE, c, cur_idx(cnt), 1'b0);
                        md  = clt_pkg::MODE_TOKEN;
                    end
                end
                clt_pkg::MODE_TOKEN, clt_pkg::MODE_TOKEN_PROTO: begin
                    md     = clt_pkg::MODE_TOKEN;
                    do_tok = 1'b1;
                end
                clt_pkg::MODE_QUOTED: begin
                    if (is_quote) begin
                        l  = put_item(l, clt_pkg::KIND_END, '0, cur_idx(cnt), 1'b0);
                        md = clt_pkg::MODE_BETWEEN;
                    end else begin
                        l = put_item(l, clt_pkg::KIND_BYTE, c, cur_idx(cnt), 1'b0);
                    end
                end
                clt_pkg::MODE_BLOCK_COMMENT: begin
                    if (ss && c == clt_pkg::CH_SLASH) begin
                        ss = 1'b0;
                        md = clt_pkg::MODE_BETWEEN;
                    end else begin
                        ss = (c == clt_pkg::CH_STAR);
                    end
                end
                default: begin
                    md = md;
                end
            endcase
        end

        // byte inside a token
        if (do_tok) begin
            if (is_sep) begin
                l  = put_item(l, clt_pkg::KIND_END, '0, cur_idx(cnt), 1'b0);
                md = clt_pkg::MODE_BETWEEN;
            end else if (is_quote) begin
                l = put_item(l, clt_pkg::KIND_END, '0, cur_idx(cnt), 1'b0);
                if (cnt >= CNT_MAX) begin
                    md = clt_pkg::MODE_STOPPED;
                    ps = 1'b0;
                end else begin
                    cnt = cnt + CNT_W'(1);
                    md  = clt_pkg::MODE_QUOTED;
                end
            end else if (c == clt_pkg::CH_SLASH) begin
                ps = 1'b1;
                md = proto ? clt_pkg::MODE_TOKEN_PROTO : clt_pkg::MODE_TOKEN;
            end else begin
                l = put_item(l, clt_pkg::KIND_BYTE, c, cur_idx(cnt), 1'b0);
            end
        end

        // history of the line
        sprev_next = prev_reg;
        prev_next  = c;
        lpos_next  = (lpos_reg == 2'd3) ? lpos_reg : lpos_reg + 2'd1;

        // end of line: flush slash, close token, report count
        if (in_eol_reg) begin
            ok = 1'b1;
            if (ps) begin
                ps = 1'b0;
                if (md == clt_pkg::MODE_BETWEEN) begin
                    if (cnt >= CNT_MAX) begin
                        md = clt_pkg::MODE_STOPPED;
                        ok = 1'b0;
                    end else begin
                        cnt = cnt + CNT_W'(1);
                    end
                end
                if (ok) begin
                    l  = put_item(l, clt_pkg::KIND_BYTE, clt_pkg::CH_SLASH,
                                  cur_idx(cnt), 1'b0);
                    md = clt_pkg::MODE_TOKEN;
                end
            end
            if (ok && (md == clt_pkg::MODE_TOKEN || md == clt_pkg::MODE_TOKEN_PROTO ||
                       md == clt_pkg::MODE_QUOTED)) begin
                l = put_item(l, clt_pkg::KIND_END, '0, cur_idx(cnt), 1'b0);
            end
            l = put_item(l, clt_pkg::KIND_DONE, '0, to_idx(cnt),
                         md == clt_pkg::MODE_STOPPED);
            md         = clt_pkg::MODE_BETWEEN;
            ps         = 1'b0;
            cnt        = '0;
            ss         = 1'b0;
            sprev_next = '0;
            prev_next  = '0;
            lpos_next  = 2'd0;
        end

        // mark the final result of this byte
        if (l.count != '0) begin
            l.items[clt_pkg::RPTR_W'(l.count - clt_pkg::RES_W'(1))].last = 1'b1;
        end
        l.load = consume;

        list        = l;
        mode_next   = md;
        pslash_next = ps;
        cnt_next    = cnt;
        star_next   = ss;
    end

    assign res_out = list;

    // input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_in;
            in_eol_reg  <= s_end_of_line;
        end
    end

    // scan state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= clt_pkg::MODE_BETWEEN;
            pslash_reg <= 1'b0;
            prev_reg   <= '0;
            sprev_reg  <= '0;
            lpos_reg   <= 2'd0;
            cnt_reg    <= '0;
            star_reg   <= 1'b0;
        end else if (consume) begin
            mode_reg   <= mode_next;
            pslash_reg <= pslash_next;
            prev_reg   <= prev_next;
            sprev_reg  <= sprev_next;
            lpos_reg   <= lpos_next;
            cnt_reg    <= cnt_next;
            star_reg   <= star_next;
        end
    end

endmodule

/* design/clt_result_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_result_buf
// Result register of the tokenizer: holds the results of one byte and hands
// them out one per request on the result channel.
// ----------------------------------------------------------------------------
module clt_result_buf (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  clt_pkg::res_list_t         res_in,
    output logic                       buf_free,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_item_kind,
    output logic [clt_pkg::CHAR_W-1:0] m_char_out,
    output logic [clt_pkg::IDX_W-1:0]  m_token_index,
    output logic                       m_overflow,
    output logic                       m_last
);

    clt_pkg::item_t [clt_pkg::MAX_RES-1:0] items_reg;
    logic [clt_pkg::RES_W-1:0]             count_reg;
    logic [clt_pkg::RPTR_W-1:0]            rptr_reg;
    clt_pkg::item_t                        head;

    // free when empty or the final entry leaves this cycle
    assign m_valid  = (count_reg != '0);
    assign buf_free = (count_reg == '0) ||
                      ((count_reg == clt_pkg::RES_W'(1)) && m_ready);

    // head entry to the ports
    assign head          = items_reg[rptr_reg];
    assign m_item_kind   = head.kind;
    assign m_char_out    = head.ch;
    assign m_token_index = head.idx;
    assign m_overflow    = head.ovf;
    assign m_last        = head.last;

    // fill and drain control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            rptr_reg  <= '0;
        end else if (res_in.load) begin
            count_reg <= res_in.count;
            rptr_reg  <= '0;
        end else if (m_valid && m_ready) begin
            count_reg <= count_reg - clt_pkg::RES_W'(1);
            rptr_reg  <= rptr_reg + clt_pkg::RPTR_W'(1);
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (res_in.load) begin
            items_reg <= res_in.items;
        end
    end

endmodule
